@@ src/pcf_pkg.sv @@
// ----------------------------------------------------------------------------
// pcf_pkg: shared types and constants for the palette crossfade engine
// Operation codes, sizes and the per-channel blend function.
// ----------------------------------------------------------------------------
`default_nettype none
package pcf_pkg;
	localparam int ENTRIES   = 160;
	localparam int TEAMS     = 256;
	localparam int ENT_W     = 8;
	localparam int TEAM_W    = 8;
	localparam int BANK_AW   = 16;
	localparam int CUR_AW    = 9;
	localparam int STEP_W    = 5;
	localparam logic [STEP_W-1:0] STEP_CLAMP = 5'd16;
	localparam logic [STEP_W-1:0] STEP_DONE  = 5'd17;

	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_BEGIN = 3'd1;
	localparam logic [2:0] OP_REQ   = 3'd2;
	localparam logic [2:0] OP_TICK  = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	typedef struct packed {
		logic [2:0]        operation;
		logic              side;
		logic [TEAM_W-1:0] team;
		logic [TEAM_W-1:0] second_team;
		logic [ENT_W-1:0]  entry;
		logic [15:0]       color;
	} item_t;

	typedef struct packed {
		logic              bank_wr;
		logic [BANK_AW-1:0] bank_wa;
		logic [15:0]       bank_wd;
		logic              bank_rd;
		logic [BANK_AW-1:0] bank_ra;
		logic              cur_rd;
		logic [CUR_AW-1:0] cur_ra;
		logic              copy_wr;
		logic              blend_wr;
		logic              snap_wr;
		logic [CUR_AW-1:0] wa;
		logic [STEP_W-1:0] step;
	} cmd_t;

	// Blue rounds the scaled delta toward zero; green and red sit above the
	// low bits and therefore round toward minus infinity.
	function automatic logic [4:0] mix5(input logic [4:0] a, input logic [4:0] b,
		input logic [STEP_W-1:0] s, input logic to_zero);
		logic signed [10:0] d;
		logic signed [10:0] q;
		logic signed [10:0] p;
		begin
			d = $signed({6'd0, b}) - $signed({6'd0, a});
			p = d * $signed({6'd0, s});
			q = (to_zero && p < 0) ? -((-p) >>> 4) : (p >>> 4);
			mix5 = 5'(11'($signed({6'd0, a}) + q));
		end
	endfunction

	function automatic logic [15:0] mix_color(input logic [15:0] a, input logic [15:0] b,
		input logic [STEP_W-1:0] s);
		logic [STEP_W-1:0] c;
		begin
			c = (s > STEP_CLAMP) ? STEP_CLAMP : s;
			mix_color = {b[15], mix5(a[14:10], b[14:10], c, 1'b0),
				mix5(a[9:5], b[9:5], c, 1'b0), mix5(a[4:0], b[4:0], c, 1'b1)};
		end
	endfunction
endpackage
`default_nettype wire

@@ src/pcf_datapath.sv @@
// ----------------------------------------------------------------------------
// pcf_datapath: palette memories and blend datapath
// Bank, current and start memories; copy, snapshot and blend write-back.
// ----------------------------------------------------------------------------
`default_nettype none
module pcf_datapath (
	input  wire logic                clk,
	input  wire pcf_pkg::cmd_t       cmd,
	output logic [15:0]              cur_q
);
	import pcf_pkg::*;

	logic [15:0] bank_mem [0:TEAMS*ENTRIES-1];
	logic [15:0] cur_mem [0:2*ENTRIES-1];
	logic [15:0] start_mem [0:2*ENTRIES-1];
	logic [15:0] bank_q, start_q, cur_rd_q;
	logic copy_s1, blend_s1, snap_s1;
	logic [CUR_AW-1:0] wa_s1;
	logic [STEP_W-1:0] step_s1;
	logic [15:0] wdata;

	always_ff @(posedge clk) begin
		if (cmd.bank_wr) bank_mem[cmd.bank_wa] <= cmd.bank_wd;
		if (cmd.bank_rd) bank_q <= bank_mem[cmd.bank_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.cur_rd) begin
			cur_rd_q <= cur_mem[cmd.cur_ra];
			start_q  <= start_mem[cmd.cur_ra];
		end
		copy_s1  <= cmd.copy_wr;
		blend_s1 <= cmd.blend_wr;
		snap_s1  <= cmd.snap_wr;
		wa_s1    <= cmd.wa;
		step_s1  <= cmd.step;
	end

	assign wdata = blend_s1 ? mix_color(start_q, bank_q, step_s1) : bank_q;

	always_ff @(posedge clk) begin
		if (copy_s1 || blend_s1) cur_mem[wa_s1] <= wdata;
		if (copy_s1) start_mem[wa_s1] <= bank_q;
		else if (snap_s1) start_mem[wa_s1] <= cur_rd_q;
	end

	assign cur_q = cur_rd_q;
endmodule
`default_nettype wire

@@ src/pcf_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcf_ctrl: sequencer for the palette crossfade engine
// Decodes items, checks validity, sweeps entries and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none
module pcf_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_ok,
	input  wire pcf_pkg::item_t      item,
	output logic                     in_rdy,
	input  wire logic [8:0]          team_count,
	output pcf_pkg::cmd_t            cmd,
	input  wire logic [15:0]         cur_q,
	output logic                     res_vld,
	input  wire logic                res_rdy,
	output logic [18:0]              res_data
);
	import pcf_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SWEEP = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0] state_q;
	logic [TEAM_W-1:0] tgt_q [2];
	logic [STEP_W-1:0] step_q [2];
	logic ready_q;
	logic [2:0] op_q;
	logic half_q;
	logic [ENT_W-1:0] idx_q;
	logic [1:0] todo_q;
	logic [1:0] chg_q;
	logic [1:0] drain_q;
	logic [TEAM_W-1:0] src_q [2];
	logic status_q;
	logic [15:0] col_q;

	logic count_ok, valid, t1_ok, t2_ok;
	logic [CUR_AW-1:0] caddr;
	logic [BANK_AW-1:0] baddr;
	logic last;
	logic [1:0] fading;

	assign count_ok = (team_count >= 9'd1) && (team_count <= 9'd256);
	assign t1_ok = {1'b0, item.team} < team_count;
	assign t2_ok = {1'b0, item.second_team} < team_count;
	assign valid = ready_q && count_ok && ({1'b0, tgt_q[0]} < team_count)
		&& ({1'b0, tgt_q[1]} < team_count);
	assign in_rdy = (state_q == S_IDLE);
	assign caddr = CUR_AW'(half_q ? ENTRIES : 0) + CUR_AW'(idx_q);
	assign baddr = BANK_AW'(src_q[half_q] * ENTRIES) + BANK_AW'(idx_q);
	assign last = (idx_q == ENT_W'(ENTRIES - 1));
	assign fading = {step_q[1] != STEP_DONE, step_q[0] != STEP_DONE};

	always_comb begin
		cmd = '0;
		cmd.bank_wa = BANK_AW'(item.team * ENTRIES) + BANK_AW'(item.entry);
		cmd.bank_wd = item.color;
		cmd.bank_wr = in_ok && in_rdy && item.operation == OP_WRITE
			&& item.entry < ENT_W'(ENTRIES);
		cmd.bank_ra = baddr;
		cmd.wa = caddr;
		cmd.step = step_q[half_q];
		cmd.cur_ra = caddr;
		if (state_q == S_READ) begin
			cmd.cur_rd = 1'b1;
			cmd.cur_ra = CUR_AW'(half_q ? ENTRIES : 0) + CUR_AW'(idx_q);
		end
		if (state_q == S_SWEEP) begin
			cmd.bank_rd = 1'b1;
			cmd.cur_rd = 1'b1;
			cmd.copy_wr = (op_q == OP_BEGIN);
			cmd.blend_wr = (op_q == OP_TICK);
			cmd.snap_wr = (op_q == OP_REQ);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tgt_q[0] <= '0;
			tgt_q[1] <= '0;
			step_q[0] <= '0;
			step_q[1] <= '0;
			ready_q <= 1'b0;
			res_vld <= 1'b0;
			op_q <= '0;
			half_q <= 1'b0;
			idx_q <= '0;
			todo_q <= '0;
			chg_q <= '0;
			drain_q <= '0;
			src_q[0] <= '0;
			src_q[1] <= '0;
			status_q <= 1'b0;
			col_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_ok) begin
						op_q <= item.operation;
						chg_q <= (item.operation == OP_TICK && valid) ? fading : 2'b00;
						col_q <= '0;
						idx_q <= (item.operation == OP_READ) ? item.entry : '0;
						case (item.operation)
							OP_WRITE: begin
								status_q <= !(item.entry < ENT_W'(ENTRIES));
								state_q <= S_OUT;
							end
							OP_BEGIN: begin
								if (count_ok && t1_ok && t2_ok) begin
									status_q <= 1'b0;
									src_q[0] <= item.team;
									src_q[1] <= item.second_team;
									todo_q <= 2'b11;
									half_q <= 1'b0;
									state_q <= S_SWEEP;
								end else begin
									status_q <= 1'b1;
									state_q <= S_OUT;
								end
							end
							OP_REQ: begin
								if (valid && t1_ok) begin
									status_q <= 1'b0;
									if (item.team != tgt_q[item.side]) begin
										tgt_q[item.side] <= item.team;
										step_q[item.side] <= '0;
										half_q <= item.side;
										todo_q <= 2'b01 << item.side;
										src_q[item.side] <= item.team;
										state_q <= S_SWEEP;
									end else state_q <= S_OUT;
								end else begin
									status_q <= 1'b1;
									state_q <= S_OUT;
								end
							end
							OP_TICK: begin
								if (valid) begin
									status_q <= 1'b0;
									todo_q <= fading;
									src_q[0] <= tgt_q[0];
									src_q[1] <= tgt_q[1];
									half_q <= (step_q[0] == STEP_DONE);
									state_q <= (fading != 2'b00) ? S_SWEEP : S_OUT;
								end else begin
									status_q <= 1'b1;
									state_q <= S_OUT;
								end
							end
							OP_READ: begin
								if (ready_q && item.entry < ENT_W'(ENTRIES)) begin
									status_q <= 1'b0;
									half_q <= item.side;
									state_q <= S_READ;
								end else begin
									status_q <= 1'b1;
									state_q <= S_OUT;
								end
							end
							default: begin
								status_q <= 1'b1;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_SWEEP: begin
					if (last) begin
						idx_q <= '0;
						todo_q[half_q] <= 1'b0;
						if (half_q == 1'b0 && todo_q[1]) half_q <= 1'b1;
						else begin
							drain_q <= 2'd2;
							state_q <= S_DRAIN;
						end
					end else idx_q <= idx_q + 1'b1;
				end
				S_DRAIN: begin
					drain_q <= drain_q - 1'b1;
					if (drain_q == 2'd1) begin
						if (op_q == OP_BEGIN) begin
							tgt_q[0] <= src_q[0];
							tgt_q[1] <= src_q[1];
							step_q[0] <= STEP_DONE;
							step_q[1] <= STEP_DONE;
							ready_q <= 1'b1;
						end
						if (op_q == OP_TICK) begin
							if (chg_q[0]) step_q[0] <= step_q[0] + 1'b1;
							if (chg_q[1]) step_q[1] <= step_q[1] + 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_READ: begin
					state_q <= S_OUT;
					op_q <= OP_WRITE;
					drain_q <= 2'd3;
				end
				S_OUT: begin
					if (drain_q == 2'd3) begin
						col_q <= cur_q;
						drain_q <= 2'd0;
					end else if (!res_vld) res_vld <= 1'b1;
					else if (res_rdy) begin
						res_vld <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_data = {col_q, chg_q, status_q};
endmodule
`default_nettype wire

@@ src/palette_crossfade_engine.sv @@
// ----------------------------------------------------------------------------
// palette_crossfade_engine: two-half RGB555 palette cross-fader
// Bank load, begin, fade request, tick and read over stream channels.
// ----------------------------------------------------------------------------
// channel | dir | fields
// s_axis  | in  | tdata: operation, side, team, second_team, entry, color
// m_axis  | out | tdata: status, changed, color_res
// cfg     | in  | team_count
// Begin sweeps both halves, tick each fading half, and a request with a new
// target its own half, one entry a cycle through the palette memory port;
// write, same-target request, reject and read do not sweep.
// The engine returns to idle before it takes the next input transfer.
// Reset clears control state; memories are undefined until written.
// A stalled result blocks the next item.
`default_nettype none
module palette_crossfade_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // operation, side, team, second_team, entry, color
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // status, changed, color_res
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [8:0]  cfg_data
);
	import pcf_pkg::*;

	item_t item;
	cmd_t cmd;
	logic [15:0] cur_q;
	logic [8:0] team_count_q;
	logic [18:0] res;
	logic rdy;

	assign item.operation   = s_axis_tdata[2:0];
	assign item.side        = s_axis_tdata[3];
	assign item.team        = s_axis_tdata[11:4];
	assign item.second_team = s_axis_tdata[19:12];
	assign item.entry       = s_axis_tdata[27:20];
	assign item.color       = s_axis_tdata[43:28];

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) team_count_q <= 9'd256;
		else if (cfg_valid) team_count_q <= cfg_data;
	end

	assign s_axis_tready = rdy;

	pcf_ctrl u_ctrl (
		.clk, .arst_n,
		.in_ok(s_axis_tvalid && rdy), .item, .in_rdy(rdy),
		.team_count(team_count_q), .cmd, .cur_q,
		.res_vld(m_axis_tvalid), .res_rdy(m_axis_tready), .res_data(res)
	);

	pcf_datapath u_dp (.clk, .cmd, .cur_q);

	assign m_axis_tdata = {5'd0, res};
endmodule
`default_nettype wire

@@ src/pcf_checker.sv @@
// ----------------------------------------------------------------------------
// pcf_checker: port-level checks for the palette crossfade engine
// Watches result handshakes, input readiness against a pending result, and result fields.
// ----------------------------------------------------------------------------
`default_nettype none
module pcf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("input open with result pending");
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] == 2'b00
		&& m_axis_tdata[18:3] == 16'd0) else $error("rejected result has data");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:19] == 5'd0) else $error("pad bits set");
endmodule

bind palette_crossfade_engine pcf_checker u_chk (.*);
`default_nettype wire
